@@ sv/sla_pkg.sv @@
// Shared types, widths, constants and the arctangent table for the segment length and angle block
`timescale 1ns / 1ps

package sla_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DELTA_W     = COORD_WIDTH + 1;
  localparam int PRESCALE    = 24;
  localparam int CORDIC_W    = DELTA_W + PRESCALE + 3;
  localparam int ATAN_W      = 22;
  localparam int ANGLE_ACC_W = 25;
  localparam int ANG_DROP    = 8;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int ROOT_W      = COORD_WIDTH + 3;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int RAD_PAD     = RAD_W - (SQ_W + 1) - 4;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int LEN_W       = 19;
  localparam int ANGLE_W     = 16;

  localparam logic [LEN_W-1:0]              LEN_REACH     = 19'd370728;
  localparam logic signed [ANGLE_W-1:0]     ANG_LIMIT     = 16'sd23040;
  localparam logic signed [ANGLE_W-1:0]     ANG_NEG_LIMIT = -16'sd23040;
  localparam logic signed [ANGLE_ACC_W-1:0] ANG_HI        = 25'sd23040;
  localparam logic signed [ANGLE_ACC_W-1:0] ANG_LO        = -25'sd23040;
  localparam logic signed [ANGLE_ACC_W-1:0] ANG_ROUND     = 25'sd128;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          start_of_path;
  } point_t;

  typedef struct packed {
    logic [LEN_W-1:0]          segment_length;
    logic signed [ANGLE_W-1:0] segment_angle;
  } seg_t;

  // Working set carried down the cell row: rotation vector, angle sum,
  // radicand shifter with partial root and remainder, and special-case flags.
  typedef struct packed {
    logic signed [CORDIC_W-1:0]    cx;
    logic signed [CORDIC_W-1:0]    cy;
    logic signed [ANGLE_ACC_W-1:0] cz;
    logic [RAD_W-1:0]              rad;
    logic [REM_W-1:0]              rem;
    logic [ROOT_W-1:0]             root;
    logic                          vert;
    logic                          horiz;
    logic                          dy_neg;
  } cell_data_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ sv/sla_cell.sv @@
// One cell of the row: a fixed-shift CORDIC vectoring step and one square root digit, either one optional
`timescale 1ns / 1ps

module sla_cell #(
  parameter int STEP      = 0,
  parameter bit ROTATE    = 1'b1,
  parameter bit ROOT_STEP = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                feed_valid,
  input  sla_pkg::cell_data_t feed,
  output logic                pass_valid,
  output sla_pkg::cell_data_t pass
);

  logic signed [sla_pkg::CORDIC_W-1:0]    xs;
  logic signed [sla_pkg::CORDIC_W-1:0]    ys;
  logic [sla_pkg::ATAN_W-1:0]             tval;
  logic signed [sla_pkg::ANGLE_ACC_W-1:0] ang;
  logic [sla_pkg::REM_W+1:0]              rem_sh;
  logic [sla_pkg::REM_W+1:0]              trial;
  logic [sla_pkg::REM_W+1:0]              diff;
  sla_pkg::cell_data_t                    step;

  always_comb begin
    xs     = feed.cx >>> STEP;
    ys     = feed.cy >>> STEP;
    tval   = sla_pkg::atan_q16(5'(STEP));
    ang    = {{(sla_pkg::ANGLE_ACC_W - sla_pkg::ATAN_W){1'b0}}, tval};
    rem_sh = {feed.rem, feed.rad[sla_pkg::RAD_W-1 -: 2]};
    trial  = {{(sla_pkg::REM_W - sla_pkg::ROOT_W){1'b0}}, feed.root, 2'b01};
    diff   = rem_sh - trial;
    step   = feed;
    if (ROTATE) begin
      // rotate toward the x axis by the sign of y
      if (!feed.cy[sla_pkg::CORDIC_W-1] && (feed.cy != '0)) begin
        step.cx = feed.cx + ys;
        step.cy = feed.cy - xs;
        step.cz = feed.cz + ang;
      end else begin
        step.cx = feed.cx - ys;
        step.cy = feed.cy + xs;
        step.cz = feed.cz - ang;
      end
    end
    if (ROOT_STEP) begin
      step.rad = {feed.rad[sla_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        step.rem  = diff[sla_pkg::REM_W-1:0];
        step.root = {feed.root[sla_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        step.rem  = rem_sh[sla_pkg::REM_W-1:0];
        step.root = {feed.root[sla_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (advance) begin
      pass_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pass <= step;
    end
  end

endmodule

@@ sv/segment_length_and_angle_top.sv @@
// Top level: point deltas, setup stages, the cell row and the result register
`timescale 1ns / 1ps
// A point's result passes stage A, stage B, the seed register, the row of cells and the
//   result register, where the row is CHAIN_LEN = max(CORDIC_STEPS, 19) cells long.
// Throughput: one point per cycle; the row of cells advances as one, so a held result
//   with a full last cell stalls the input.
// Reset clears all valid flags and the stored-point flag; the first point after reset
//   starts a path whatever its start flag says.

module segment_length_and_angle_top #(
  parameter int CORDIC_STEPS = 18 // 8 to 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_stall,
  input  sla_pkg::point_t point,
  output logic            seg_valid,
  input  logic            seg_stall,
  output sla_pkg::seg_t   seg
);

  localparam int CHAIN_LEN = (CORDIC_STEPS > sla_pkg::SQRT_STEPS) ?
                             CORDIC_STEPS : sla_pkg::SQRT_STEPS;
  localparam int CW = sla_pkg::COORD_WIDTH;
  localparam int DW = sla_pkg::DELTA_W;

  // handshake and stored point
  logic                 advance;
  logic                 accept;
  logic                 produce;
  logic                 have_previous;
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;

  // stage A: deltas
  logic                 valid_a;
  logic signed [DW-1:0] dx_a;
  logic signed [DW-1:0] dy_a;

  // stage B: squares, CORDIC start vector, flags
  logic signed [DW-1:0]                 neg_dx;
  logic signed [DW-1:0]                 neg_dy;
  logic signed [DW-1:0]                 cdx;
  logic signed [DW-1:0]                 cdy;
  logic [CW-1:0]                        ax;
  logic [CW-1:0]                        ay;
  logic                                 valid_b;
  logic signed [sla_pkg::CORDIC_W-1:0]  cx_b;
  logic signed [sla_pkg::CORDIC_W-1:0]  cy_b;
  logic [sla_pkg::SQ_W-1:0]             sqx_b;
  logic [sla_pkg::SQ_W-1:0]             sqy_b;
  logic                                 vert_b;
  logic                                 horiz_b;
  logic                                 dyneg_b;

  // stage C seeds the row
  logic [sla_pkg::SQ_W:0] sq_sum;
  sla_pkg::cell_data_t    seed_next;
  logic                   seed_valid;
  sla_pkg::cell_data_t    seed;

  logic                chain_valid [CHAIN_LEN+1];
  sla_pkg::cell_data_t chain_data  [CHAIN_LEN+1];

  // result
  sla_pkg::cell_data_t                    last;
  logic                                   round_up;
  logic [sla_pkg::ROOT_W:0]               len_sum;
  logic [sla_pkg::LEN_W-1:0]              len;
  logic signed [sla_pkg::ANGLE_ACC_W-1:0] z_round;
  logic signed [sla_pkg::ANGLE_ACC_W-1:0] z_deg;
  logic signed [sla_pkg::ANGLE_W-1:0]     angle;
  sla_pkg::seg_t                          seg_next;

  // The whole row moves together; it holds only when the last cell has a result and the
  // output register is full and stalled.
  assign advance     = !(chain_valid[CHAIN_LEN] && seg_valid && seg_stall);
  assign point_stall = !advance;
  assign accept      = point_valid && advance;
  // A start flag, or no stored point yet, only stores the point.
  assign produce     = !point.start_of_path && have_previous;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
    end else if (accept) begin
      have_previous <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= point.x_coord;
      prev_y <= point.y_coord;
    end
  end

  // Stage A: take the deltas against the stored point at the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (advance) begin
      valid_a <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx_a <= {point.x_coord[CW-1], point.x_coord} - {prev_x[CW-1], prev_x};
      dy_a <= {point.y_coord[CW-1], point.y_coord} - {prev_y[CW-1], prev_y};
    end
  end

  // Stage B: mirror into the right half-plane (atan(dy/dx) is unchanged when both
  // deltas flip), scale up for CORDIC, and square the magnitudes for the length.
  always_comb begin
    neg_dx = -dx_a;
    neg_dy = -dy_a;
    cdx    = dx_a[DW-1] ? neg_dx : dx_a;
    cdy    = dx_a[DW-1] ? neg_dy : dy_a;
    ax     = dx_a[DW-1] ? neg_dx[CW-1:0] : dx_a[CW-1:0];
    ay     = dy_a[DW-1] ? neg_dy[CW-1:0] : dy_a[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (advance) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cx_b    <= {{(sla_pkg::CORDIC_W - DW - sla_pkg::PRESCALE){cdx[DW-1]}}, cdx,
                  {sla_pkg::PRESCALE{1'b0}}};
      cy_b    <= {{(sla_pkg::CORDIC_W - DW - sla_pkg::PRESCALE){cdy[DW-1]}}, cdy,
                  {sla_pkg::PRESCALE{1'b0}}};
      sqx_b   <= ax * ax;
      sqy_b   <= ay * ay;
      vert_b  <= (dx_a == '0);
      horiz_b <= (dy_a == '0);
      dyneg_b <= dy_a[DW-1];
    end
  end

  // Stage C: radicand is 16 * (dx^2 + dy^2) so the root carries two fractional bits.
  always_comb begin
    sq_sum           = {1'b0, sqx_b} + {1'b0, sqy_b};
    seed_next.cx     = cx_b;
    seed_next.cy     = cy_b;
    seed_next.cz     = '0;
    seed_next.rad    = {{sla_pkg::RAD_PAD{1'b0}}, sq_sum, 4'b0000};
    seed_next.rem    = '0;
    seed_next.root   = '0;
    seed_next.vert   = vert_b;
    seed_next.horiz  = horiz_b;
    seed_next.dy_neg = dyneg_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
    end else if (advance) begin
      seed_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seed <= seed_next;
    end
  end

  assign chain_valid[0] = seed_valid;
  assign chain_data[0]  = seed;

  // Row of cells: cell k does CORDIC step k while k < CORDIC_STEPS and root digit k
  // while k < 19, otherwise it passes that part through.
  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    sla_cell #(
      .STEP      (k),
      .ROTATE    (k < CORDIC_STEPS),
      .ROOT_STEP (k < sla_pkg::SQRT_STEPS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .feed_valid (chain_valid[k]),
      .feed       (chain_data[k]),
      .pass_valid (chain_valid[k+1]),
      .pass       (chain_data[k+1])
    );
  end

  // Finish: round the root to the nearest quarter, round the angle to 8 fractional bits,
  // clamp, and apply the vertical and horizontal cases.
  always_comb begin
    last     = chain_data[CHAIN_LEN];
    round_up = last.rem > {{(sla_pkg::REM_W - sla_pkg::ROOT_W){1'b0}}, last.root};
    len_sum  = {1'b0, last.root} + {{sla_pkg::ROOT_W{1'b0}}, round_up};
    // saturate on carry out
    len      = len_sum[sla_pkg::ROOT_W] ? '1 : len_sum[sla_pkg::LEN_W-1:0];
    z_round  = last.cz + sla_pkg::ANG_ROUND;
    z_deg    = z_round >>> sla_pkg::ANG_DROP;
    if (z_deg > sla_pkg::ANG_HI) begin
      angle = sla_pkg::ANG_LIMIT;
    end else if (z_deg < sla_pkg::ANG_LO) begin
      angle = sla_pkg::ANG_NEG_LIMIT;
    end else begin
      angle = z_deg[sla_pkg::ANGLE_W-1:0];
    end
    if (last.vert) begin
      if (last.horiz) begin
        angle = '0;
      end else if (last.dy_neg) begin
        angle = sla_pkg::ANG_NEG_LIMIT;
      end else begin
        angle = sla_pkg::ANG_LIMIT;
      end
    end else if (last.horiz) begin
      angle = '0;
    end
    seg_next.segment_length = len;
    seg_next.segment_angle  = angle;
  end

  // Output register: load from the last cell, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (advance && chain_valid[CHAIN_LEN]) begin
      seg_valid <= 1'b1;
    end else if (!seg_stall) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && chain_valid[CHAIN_LEN]) begin
      seg <= seg_next;
    end
  end

endmodule

@@ sv/sla_checker.sv @@
// Port-level checks for the segment length and angle block, bound to its top level
`timescale 1ns / 1ps

module sla_checker (
  input logic            clk,
  input logic            rst,
  input logic            point_stall,
  input logic            seg_valid,
  input logic            seg_stall,
  input sla_pkg::seg_t   seg
);

  // hold a stalled result
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("result changed while stalled");

  // input stalls only come back from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> seg_valid && seg_stall)
    else $error("input stalled without a stalled result");

  // a zero-length segment has zero angle
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    seg_valid && (seg.segment_length == '0) |-> seg.segment_angle == '0)
    else $error("zero-length segment with nonzero angle");

  // results stay in their ranges
  a_range: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> (seg.segment_length <= sla_pkg::LEN_REACH) &&
                  (seg.segment_angle <= sla_pkg::ANG_LIMIT) &&
                  (seg.segment_angle >= sla_pkg::ANG_NEG_LIMIT))
    else $error("result out of range");

  // reset empties the output
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !seg_valid)
    else $error("result present right after reset");

endmodule

bind segment_length_and_angle_top sla_checker u_sla_checker (.*);

@@ bench/sla_checker.sv @@
// Transfer monitor, segment predictor and result comparison for the segment length and angle block
`timescale 1ns / 1ps

module sla_bench_checker #(
  parameter int STEPS = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  input  logic            point_stall,
  input  sla_pkg::point_t point,
  input  logic            seg_valid,
  input  logic            seg_stall,
  input  sla_pkg::seg_t   seg,
  output int unsigned     fail_count,
  output int unsigned     open_count
);

  localparam longint LEN_CAP   = 524287;
  localparam longint ANGLE_CAP = 23040;

  // atan(2^-i) in degrees, 16 fractional bits
  localparam longint ATAN_DEG [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  sla_pkg::seg_t pending_segments[$];
  longint        last_x;
  longint        last_y;
  bit            have_last;
  int unsigned   fails;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, rest, probe;
    root  = 0;
    rest  = v;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Length in quarter units, rounded half up
  function automatic longint quarter_length(input longint dx, input longint dy);
    longint unsigned ax, ay, v, r;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > 131071 || ay > 131071) return LEN_CAP;
    v = 16 * (ax * ax + ay * ay);
    r = int_sqrt(v);
    if (v - r * r > r) r++;
    return (r > LEN_CAP) ? LEN_CAP : r;
  endfunction

  // Vectoring rotation of (dx, dy) onto the x axis; degrees with 8 fractional bits
  function automatic longint cordic_degrees(input longint dx, input longint dy);
    longint vx, vy, acc, xs, ys, deg;
    int     n;
    if (dx == 0) return (dy > 0) ? ANGLE_CAP : ((dy < 0) ? -ANGLE_CAP : 0);
    if (dy == 0) return 0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
    end
    n   = (STEPS > 32) ? 32 : STEPS;
    vx  = dx * 16777216;
    vy  = dy * 16777216;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        acc = acc + ATAN_DEG[i];
      end else begin
        vx  = vx - ys;
        vy  = vy + xs;
        acc = acc - ATAN_DEG[i];
      end
    end
    deg = (acc + 128) >>> 8;
    if (deg > ANGLE_CAP) deg = ANGLE_CAP;
    if (deg < -ANGLE_CAP) deg = -ANGLE_CAP;
    return deg;
  endfunction

  always @(posedge clk) begin
    sla_pkg::seg_t want;
    sla_pkg::seg_t got;
    longint        px, py;
    if (rst) begin
      pending_segments.delete();
      last_x    = 0;
      last_y    = 0;
      have_last = 1'b0;
    end else begin
      // compare first, so a result never meets its own point in one edge
      if (seg_valid && !seg_stall) begin
        got = seg;
        if (pending_segments.size() == 0) begin
          fails++;
          $display("%0t: result with no segment pending: length %0d angle %0d",
                   $time, got.segment_length, got.segment_angle);
        end else begin
          want = pending_segments.pop_front();
          if (got.segment_length !== want.segment_length) begin
            fails++;
            $display("%0t: segment_length mismatch: expected %0d, actual %0d",
                     $time, want.segment_length, got.segment_length);
          end
          if (got.segment_angle !== want.segment_angle) begin
            fails++;
            $display("%0t: segment_angle mismatch: expected %0d, actual %0d",
                     $time, want.segment_angle, got.segment_angle);
          end
        end
      end
      if (point_valid && !point_stall) begin
        px = longint'(point.x_coord);
        py = longint'(point.y_coord);
        if (!point.start_of_path && have_last) begin
          want.segment_length = 19'(quarter_length(px - last_x, py - last_y));
          want.segment_angle  = 16'(cordic_degrees(px - last_x, py - last_y));
          pending_segments.push_back(want);
        end
        last_x    = px;
        last_y    = py;
        have_last = 1'b1;
      end
    end
    fail_count <= fails;
    open_count <= pending_segments.size();
  end

endmodule

@@ bench/tb_segment_length_and_angle_top.sv @@
// Stimulus, receiver back-pressure and verdict for the segment length and angle block
`timescale 1ns / 1ps

module tb_segment_length_and_angle_top;

  localparam int STEPS        = 18;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            point_valid = 1'b0;
  logic            point_stall;
  sla_pkg::point_t point = '0;
  logic            seg_valid;
  logic            seg_stall = 1'b0;
  sla_pkg::seg_t   seg;

  int unsigned     fail_count;
  int unsigned     open_count;
  int unsigned     sent_count = 0;
  int unsigned     cycle_count = 0;
  bit              stall_hold = 1'b0;

  segment_length_and_angle_top #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point      (point),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg)
  );

  sla_bench_checker #(
    .STEPS(STEPS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point      (point),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[segment_length_and_angle_top] ERROR");
      $finish;
    end
  end

  // Sender idle time: mostly back to back or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one point, hold it until the transfer, then idle for a random gap.
  // Called right after a rising edge, so valid and payload change once per step.
  task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic start);
    int gap;
    point_valid <= 1'b1;
    point       <= '{x_coord: x, y_coord: y, start_of_path: start};
    @(posedge clk);
    while (point_stall) @(posedge clk);
    sent_count++;
    // keep offering without pause while the receiver holds off
    gap = stall_hold ? 0 : pick_gap();
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Extremes, each direction class and the special cases.
  task automatic directed_points();
    // first point after reset with no start flag still opens a path
    offer_point(16'sd5, 16'sd7, 1'b0);
    offer_point(16'sd5, 16'sd7, 1'b0);           // zero-length segment
    offer_point(16'sd5, 16'sd20, 1'b0);          // vertical, upward
    offer_point(16'sd5, -16'sd3, 1'b0);          // vertical, downward
    offer_point(16'sd100, -16'sd3, 1'b0);        // horizontal, positive dx
    offer_point(-16'sd50, -16'sd3, 1'b0);        // horizontal, negative dx
    offer_point(-16'sd32768, -16'sd32768, 1'b1); // new path at the corner
    offer_point(16'sd32767, 16'sd32767, 1'b0);   // longest segment
    offer_point(-16'sd32768, 16'sd32767, 1'b0);  // most negative dx, dy zero
    offer_point(16'sd32767, -16'sd32768, 1'b0);  // dx max, dy min
    offer_point(-16'sd32768, 16'sd32767, 1'b0);  // dx min, dy max
    offer_point(16'sd0, 16'sd0, 1'b1);
    offer_point(16'sd0, 16'sd0, 1'b1);           // two starts in a row
    offer_point(16'sd1, 16'sd1, 1'b0);           // 45 degrees
    offer_point(16'sd4, 16'sd3, 1'b0);
    offer_point(16'sd3, 16'sd8, 1'b0);           // negative dx, positive dy
    offer_point(16'sd5, -16'sd92, 1'b0);         // steep downward
    offer_point(16'sd32767, -16'sd92, 1'b0);     // long and flat
    offer_point(16'sd32766, 16'sd32767, 1'b0);   // nearly vertical
    offer_point(-16'sd32768, 16'sd32766, 1'b0);  // nearly horizontal, backward
    offer_point(-16'sd32768, -16'sd32768, 1'b0); // vertical, long downward
  endtask

  // Paths of random length; steps are mostly small, with jumps, axis moves,
  // extremes and repeats mixed in, and now and then a missing start flag.
  task automatic random_paths(input int total);
    logic signed [15:0] cx, cy;
    int                 hops, kind;
    cx = '0;
    cy = '0;
    while (sent_count < total) begin
      hops = $urandom_range(0, 12);
      if ($urandom_range(0, 9) != 0) begin
        cx = 16'($urandom);
        cy = 16'($urandom);
        offer_point(cx, cy, 1'b1);
      end
      for (int k = 0; k < hops; k++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3, 4: begin
            cx = cx + 16'($urandom_range(0, 127)) - 16'd64;
            cy = cy + 16'($urandom_range(0, 127)) - 16'd64;
          end
          5: begin
            cx = 16'($urandom);
            cy = 16'($urandom);
          end
          6: begin
            cy = cy + 16'($urandom);
          end
          7: begin
            cx = cx + 16'($urandom);
          end
          8: begin
            cx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            cy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          end
          default: begin
          end
        endcase
        offer_point(cx, cy, 1'b0);
      end
    end
  endtask

  // Receiver: stall in random stretches, with one long hold-off that fills the block.
  initial begin : receiver
    int roll, span;
    bit held;
    held = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!held && sent_count >= 400) begin
        held       = 1'b1;
        stall_hold = 1'b1;
        seg_stall <= 1'b1;
        repeat (300) @(posedge clk);
        stall_hold = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          seg_stall <= 1'b0;
          span = $urandom_range(1, 24);
        end else if (roll < 85) begin
          seg_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (roll < 97) begin
          seg_stall <= 1'($urandom_range(0, 1));
          span = 1;
        end else begin
          seg_stall <= 1'b1;
          span = $urandom_range(15, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_points();
    random_paths(sent_count + RANDOM_ITEMS);
    point_valid <= 1'b0;
    // drain every pending result, then let the pipeline settle
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("[segment_length_and_angle_top] OK");
    end else begin
      $display("[segment_length_and_angle_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sla_pkg.sv
sv/sla_cell.sv
sv/segment_length_and_angle_top.sv
sv/sla_checker.sv
bench/sla_checker.sv
bench/tb_segment_length_and_angle_top.sv
